### design/rrv_pkg.sv
package rrv_pkg;

  localparam int VALUE_W = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_STORE,
    S_EMIT,
    S_FLUSH
  } rrv_state_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic store;
    logic emit;
    logic flush;
  } rrv_cmd_t;

  typedef struct packed {
    logic full;
    logic final_q;
    logic scan_done;
  } rrv_status_t;

endpackage

### design/rrv_ctrl.sv
module rrv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                is_final,
  input  rrv_pkg::rrv_status_t status,
  output rrv_pkg::rrv_cmd_t    cmd,
  output logic                busy
);
  import rrv_pkg::*;

  rrv_state_t state;
  rrv_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (status.full) begin
            state_next = is_final ? S_EMIT : S_IDLE;
          end else begin
            state_next = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (status.scan_done) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        state_next = status.final_q ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (status.scan_done) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_CMP: begin
        cmd.compare = 1'b1;
      end
      S_STORE: begin
        cmd.store = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

### design/rrv_dp.sv
module rrv_dp #(
  parameter int MAX_LEN = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rrv_pkg::rrv_cmd_t                  cmd,
  input  logic signed [rrv_pkg::VALUE_W-1:0] value,
  input  logic                               is_final,
  output rrv_pkg::rrv_status_t               status,
  output logic                               strobe,
  output logic signed [rrv_pkg::VALUE_W-1:0] kept_value,
  output logic                               end_of_run,
  output logic                               none_left,
  output logic                               overflowed
);
  import rrv_pkg::*;

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  // each entry holds the repeat flag above the value
  logic [VALUE_W:0]   mem [MAX_LEN];
  logic [VALUE_W:0]   rdata;
  logic [VALUE_W-1:0] val;
  logic [VALUE_W-1:0] pending;
  logic               fin;
  logic               seen;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   cmp_idx;
  logic               rd_valid;
  logic               have_pending;
  logic               ovf;
  logic               issue;
  logic               hit;
  logic               keep;

  assign issue = (cmd.compare || cmd.emit) && (rd_idx < count);
  assign hit   = cmd.compare && rd_valid && (rdata[VALUE_W-1:0] == val);
  assign keep  = cmd.emit && rd_valid && !rdata[VALUE_W];

  assign status.full      = (count == CNT_W'(MAX_LEN));
  assign status.final_q   = fin;
  assign status.scan_done = (rd_idx == count) && !rd_valid;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[count[IDX_W-1:0]] <= {seen, val};
    end else if (hit) begin
      mem[cmp_idx] <= {1'b1, rdata[VALUE_W-1:0]};
    end
    if (issue) begin
      rdata <= mem[rd_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      rd_idx       <= '0;
      rd_valid     <= 1'b0;
      ovf          <= 1'b0;
      have_pending <= 1'b0;
      strobe       <= 1'b0;
    end else begin
      strobe <= (keep && have_pending) || cmd.flush;
      if (cmd.capture) begin
        rd_idx   <= '0;
        rd_valid <= 1'b0;
        if (status.full) begin
          ovf <= 1'b1;
        end
      end
      if (cmd.compare || cmd.emit) begin
        rd_valid <= issue;
        if (issue) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
      end
      if (cmd.store) begin
        count    <= count + CNT_W'(1);
        rd_idx   <= '0;
        rd_valid <= 1'b0;
      end
      if (keep) begin
        have_pending <= 1'b1;
      end
      if (cmd.flush) begin
        count        <= '0;
        ovf          <= 1'b0;
        have_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      val  <= value;
      fin  <= is_final;
      seen <= 1'b0;
    end
    if (issue) begin
      cmp_idx <= rd_idx[IDX_W-1:0];
    end
    if (hit) begin
      seen <= 1'b1;
    end
    if (keep) begin
      pending <= rdata[VALUE_W-1:0];
      if (have_pending) begin
        kept_value <= pending;
        end_of_run <= 1'b0;
        none_left  <= 1'b0;
        overflowed <= ovf;
      end
    end
    if (cmd.flush) begin
      kept_value <= have_pending ? pending : '0;
      end_of_run <= 1'b1;
      none_left  <= !have_pending;
      overflowed <= ovf;
    end
  end

endmodule

### design/remove_repeated_values_unit.sv
// Channel   Handshake        Payload
// input     start / busy     value, is_final
// result    strobe           kept_value, end_of_run, none_left, overflowed
//
// An item reads the values already stored, one read of the value memory per
// cycle, each compared against the item, then stores the item. A final item
// then scans the memory again and flushes; the last result is strobed on the
// first cycle with busy low. A full buffer drops the item, then scans and
// flushes if the item is final.
// Reset is synchronous, active high. Results are strobed for one cycle each
// and cannot be stalled.
module remove_repeated_values_unit #(
  parameter int MAX_LEN = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [rrv_pkg::VALUE_W-1:0] value,
  input  logic                               is_final,
  output logic                               strobe,
  output logic signed [rrv_pkg::VALUE_W-1:0] kept_value,
  output logic                               end_of_run,
  output logic                               none_left,
  output logic                               overflowed
);
  import rrv_pkg::*;

  rrv_cmd_t    cmd;
  rrv_status_t status;

  rrv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .is_final (is_final),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  rrv_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .value      (value),
    .is_final   (is_final),
    .status     (status),
    .strobe     (strobe),
    .kept_value (kept_value),
    .end_of_run (end_of_run),
    .none_left  (none_left),
    .overflowed (overflowed)
  );

`ifndef ASSERT_OFF
  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && none_left |-> end_of_run)
    else $error("empty result not marked as last");

  a_last_when_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && end_of_run |-> !busy)
    else $error("last result while still busy");

  a_mid_when_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !end_of_run |-> busy)
    else $error("inner result outside a scan");
`endif

endmodule
